// ===== src/va_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package va_pkg;

  // Fixed field widths of the event and result channels
  localparam int OP_W       = 2;
  localparam int TIME_W     = 32;
  localparam int PITCH_W    = 7;
  localparam int VIDX_W     = 4;
  localparam int STAT_W     = 4;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_STEAL = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON    = 2'd0,
    OP_NOTE_OFF   = 2'd1,
    OP_VOICE_DONE = 2'd2,
    OP_KILL_ALL   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_STARTED   = 4'd0,
    STAT_STOLEN    = 4'd1,
    STAT_RETRIG    = 4'd2,
    STAT_NONE_FREE = 4'd3,
    STAT_RELEASED  = 4'd4,
    STAT_NO_MATCH  = 4'd5,
    STAT_FREED     = 4'd6,
    STAT_IGNORED   = 4'd7,
    STAT_ALL_REL   = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_FREE,
    ST_SCAN,
    ST_PICK,
    ST_COMMIT
  } state_t;

  // Voice state update applied when the result is handed over
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_RELEASE,
    ACT_FREE,
    ACT_KILL
  } act_t;

  // What the table scan is looking for
  typedef enum logic [1:0] {
    SCAN_STEAL,
    SCAN_OFF_ANY,
    SCAN_OFF_NAMED
  } scan_t;

endpackage

`default_nettype wire

// ===== src/voice_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Named note on, voice done and kill all commit straight after decode; named note off reads
// the named voice's entry. Note on by allocation finds (last + 1) mod L by subtraction (L =
// effective voice limit), then checks up to L voices for a free one; a steal adds an oldest
// scan through the single memory read port. Note off by pitch scans L memory entries.
// A new request is taken only once the previous result is handed over; a stalled result holds it off.
// Synchronous active-low reset frees all voices and restores register defaults.

module voice_allocator
  import va_pkg::*;
#(
  parameter int NUM_VOICES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // event channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [TIME_W-1:0]     in_timestamp,
  input  wire logic [PITCH_W-1:0]    in_pitch,
  input  wire logic                  in_voice_any,
  input  wire logic [VIDX_W-1:0]     in_voice_index,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STAT_W-1:0]          out_status,
  output logic [VIDX_W-1:0]          out_voice_out,
  output logic                       out_need_fade
);

  localparam int VW = $clog2(NUM_VOICES);
  localparam int LW = $clog2(NUM_VOICES + 1);
  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
  localparam int MW = PITCH_W + TIME_W;

  // Voice number to result field width
  function automatic logic [VIDX_W-1:0] to_vout(input logic [VW-1:0] v);
    logic [CW-1:0] tmp;
    tmp = CW'(v);
    return tmp[VIDX_W-1:0];
  endfunction

  // Control state
  state_t            state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic              steal_r;
  logic [NUM_VOICES-1:0] busy_r, busy_nxt;
  logic [NUM_VOICES-1:0] key_r, key_nxt;
  logic [VW-1:0]     last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              issue_r, issue_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;

  // Latched request
  op_t               op_r;
  logic [TIME_W-1:0] time_r;
  logic [PITCH_W-1:0] pitch_r;
  logic              any_r;
  logic [VIDX_W-1:0] idx_r;

  // Round-robin and scan datapath
  logic [CW-1:0]     mod_r, mod_nxt;
  logic [VW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  scan_t             kind_r, kind_nxt;
  logic [VW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [VW-1:0]     end_r, end_nxt;
  logic [VW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              have_r, have_nxt;
  logic [VW-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0] best_t_r, best_t_nxt;

  // Pending result and voice update
  status_t           res_status_r, res_status_nxt;
  logic [VIDX_W-1:0] res_voice_r, res_voice_nxt;
  logic              res_fade_r, res_fade_nxt;
  act_t              act_r, act_nxt;
  logic [VW-1:0]     act_voice_r, act_voice_nxt;

  // Output register
  status_t           out_status_r;
  logic [VIDX_W-1:0] out_voice_r;
  logic              out_fade_r;

  // Pitch and start time per voice
  logic [MW-1:0]     vmem_r [NUM_VOICES];
  logic [MW-1:0]     rd_data_r;

  // Handshake and strobes
  logic              in_acc;
  logic              out_free;
  logic              commit_fire;
  logic              mem_rd_en;
  logic              mem_we;

  // Derived values
  logic [CW-1:0]     lim_raw;
  logic [CW-1:0]     lim;
  logic [CW-1:0]     lim_m1;
  logic [CW-1:0]     idx_ext;
  logic [VW-1:0]     idx_v;
  logic              idx_ok;
  logic [PITCH_W-1:0] rd_pitch;
  logic [TIME_W-1:0] rd_time;
  logic              cand;
  logic              take;

  // Effective voice limit, clamped to 1..NUM_VOICES
  always_comb begin
    lim_raw = CW'(limit_r);
    if (lim_raw == '0) begin
      lim = CW'(1);
    end else if (lim_raw > CW'(NUM_VOICES)) begin
      lim = CW'(NUM_VOICES);
    end else begin
      lim = lim_raw;
    end
  end

  assign lim_m1   = lim - CW'(1);
  assign idx_ext  = CW'(idx_r);
  assign idx_v    = idx_ext[VW-1:0];
  assign idx_ok   = (idx_ext < CW'(NUM_VOICES));
  assign rd_pitch = rd_data_r[TIME_W +: PITCH_W];
  assign rd_time  = rd_data_r[TIME_W-1:0];

  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Scan compare: strict less-than keeps the lowest index on a tie
  assign cand = (kind_r == SCAN_STEAL) ||
                (busy_r[cmp_idx_r] && key_r[cmp_idx_r] && (rd_pitch == pitch_r));
  assign take = cmp_vld_r && cand && (!have_r || (rd_time < best_t_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (op_r)
          OP_NOTE_ON:  state_nxt = any_r ? ST_MOD : ST_COMMIT;
          OP_NOTE_OFF: state_nxt = (any_r || idx_ok) ? ST_SCAN : ST_COMMIT;
          OP_VOICE_DONE, OP_KILL_ALL: state_nxt = ST_COMMIT;
          default: state_nxt = ST_COMMIT;
        endcase
      end
      ST_MOD: begin
        if (mod_r < lim) state_nxt = ST_FREE;
      end
      ST_FREE: begin
        if (!busy_r[cur_r]) begin
          state_nxt = ST_COMMIT;
        end else if (cnt_r == lim_m1) begin
          state_nxt = steal_r ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && (cmp_idx_r == end_r)) state_nxt = ST_PICK;
      end
      ST_PICK: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall    = (state_r != ST_IDLE) || !rst_n;
    mem_rd_en   = (state_r == ST_SCAN) && issue_r;
    commit_fire = (state_r == ST_COMMIT) && out_free;
    mem_we      = commit_fire && (act_r == ACT_START);
  end

  // Datapath next values
  always_comb begin
    mod_nxt        = mod_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    rd_addr_nxt    = rd_addr_r;
    end_nxt        = end_r;
    issue_nxt      = issue_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    have_nxt       = have_r;
    best_idx_nxt   = best_idx_r;
    best_t_nxt     = best_t_r;
    res_status_nxt = res_status_r;
    res_voice_nxt  = res_voice_r;
    res_fade_nxt   = res_fade_r;
    act_nxt        = act_r;
    act_voice_nxt  = act_voice_r;
    busy_nxt       = busy_r;
    key_nxt        = key_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (state_r)
      ST_DECODE: begin
        res_fade_nxt = 1'b0;
        act_nxt      = ACT_NONE;
        unique case (op_r)
          OP_NOTE_ON: begin
            if (any_r) begin
              mod_nxt = CW'(last_r) + CW'(1);
            end else if (!idx_ok) begin
              res_status_nxt = STAT_IGNORED;
              res_voice_nxt  = '0;
            end else begin
              res_status_nxt = busy_r[idx_v] ? STAT_RETRIG : STAT_STARTED;
              res_voice_nxt  = idx_r;
              act_nxt        = ACT_START;
              act_voice_nxt  = idx_v;
            end
          end
          OP_NOTE_OFF: begin
            issue_nxt = 1'b1;
            have_nxt  = 1'b0;
            if (any_r) begin
              kind_nxt    = SCAN_OFF_ANY;
              rd_addr_nxt = '0;
              end_nxt     = lim_m1[VW-1:0];
            end else begin
              kind_nxt    = SCAN_OFF_NAMED;
              rd_addr_nxt = idx_v;
              end_nxt     = idx_v;
              if (!idx_ok) begin
                issue_nxt      = 1'b0;
                res_status_nxt = STAT_NO_MATCH;
                res_voice_nxt  = idx_r;
              end
            end
          end
          OP_VOICE_DONE: begin
            res_voice_nxt = idx_r;
            if (idx_ok && (idx_ext < lim) && busy_r[idx_v] && !key_r[idx_v]) begin
              res_status_nxt = STAT_FREED;
              act_nxt        = ACT_FREE;
              act_voice_nxt  = idx_v;
            end else begin
              res_status_nxt = STAT_IGNORED;
            end
          end
          OP_KILL_ALL: begin
            res_status_nxt = STAT_ALL_REL;
            res_voice_nxt  = '0;
            act_nxt        = ACT_KILL;
          end
          default: act_nxt = ACT_NONE;
        endcase
      end

      // Round-robin start: (last + 1) mod limit by repeated subtraction
      ST_MOD: begin
        if (mod_r >= lim) begin
          mod_nxt = mod_r - lim;
        end else begin
          cur_nxt = mod_r[VW-1:0];
          cnt_nxt = '0;
        end
      end

      // Free-voice search, one voice per cycle
      ST_FREE: begin
        if (!busy_r[cur_r]) begin
          res_status_nxt = STAT_STARTED;
          res_voice_nxt  = to_vout(cur_r);
          act_nxt        = ACT_START;
          act_voice_nxt  = cur_r;
        end else if (cnt_r == lim_m1) begin
          if (steal_r) begin
            kind_nxt    = SCAN_STEAL;
            rd_addr_nxt = '0;
            end_nxt     = lim_m1[VW-1:0];
            issue_nxt   = 1'b1;
            have_nxt    = 1'b0;
          end else begin
            res_status_nxt = STAT_NONE_FREE;
            res_voice_nxt  = '0;
          end
        end else begin
          cur_nxt = ((CW'(cur_r) + CW'(1)) == lim) ? '0 : cur_r + VW'(1);
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // Memory scan: each read is issued in the cycle before its compare
      ST_SCAN: begin
        if (issue_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_addr_r;
          if (rd_addr_r == end_r) begin
            issue_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r + VW'(1);
          end
        end
        if (take) begin
          have_nxt     = 1'b1;
          best_idx_nxt = cmp_idx_r;
          best_t_nxt   = rd_time;
        end
      end

      ST_PICK: begin
        if (kind_r == SCAN_STEAL) begin
          res_status_nxt = STAT_STOLEN;
          res_voice_nxt  = to_vout(best_idx_r);
          res_fade_nxt   = busy_r[best_idx_r];
          act_nxt        = ACT_START;
          act_voice_nxt  = best_idx_r;
        end else if (have_r) begin
          res_status_nxt = STAT_RELEASED;
          res_voice_nxt  = to_vout(best_idx_r);
          act_nxt        = ACT_RELEASE;
          act_voice_nxt  = best_idx_r;
        end else begin
          res_status_nxt = STAT_NO_MATCH;
          res_voice_nxt  = (kind_r == SCAN_OFF_NAMED) ? idx_r : '0;
        end
      end

      // Hand over the result and apply the voice update together
      ST_COMMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          unique case (act_r)
            ACT_START: begin
              busy_nxt[act_voice_r] = 1'b1;
              key_nxt[act_voice_r]  = 1'b1;
              last_nxt              = act_voice_r;
            end
            ACT_RELEASE: key_nxt[act_voice_r] = 1'b0;
            ACT_FREE:    busy_nxt[act_voice_r] = 1'b0;
            ACT_KILL: begin
              busy_nxt = '0;
              key_nxt  = '0;
            end
            ACT_NONE: last_nxt = last_r;
            default:  last_nxt = last_r;
          endcase
        end
      end

      default: cmp_vld_nxt = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_W'(16);
      steal_r     <= 1'b1;
      busy_r      <= '0;
      key_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      key_r       <= key_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VOICE_LIMIT: limit_r <= cfg_wdata;
          CFG_ALLOW_STEAL: steal_r <= cfg_wdata[0];
          default:         steal_r <= steal_r;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op_t'(in_op);
      time_r  <= in_timestamp;
      pitch_r <= in_pitch;
      any_r   <= in_voice_any;
      idx_r   <= in_voice_index;
    end
    mod_r        <= mod_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    kind_r       <= kind_nxt;
    rd_addr_r    <= rd_addr_nxt;
    end_r        <= end_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    have_r       <= have_nxt;
    best_idx_r   <= best_idx_nxt;
    best_t_r     <= best_t_nxt;
    res_status_r <= res_status_nxt;
    res_voice_r  <= res_voice_nxt;
    res_fade_r   <= res_fade_nxt;
    act_r        <= act_nxt;
    act_voice_r  <= act_voice_nxt;
    if (commit_fire) begin
      out_status_r <= res_status_r;
      out_voice_r  <= res_voice_r;
      out_fade_r   <= res_fade_r;
    end
  end

  // Pitch/time memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) vmem_r[act_voice_r] <= {pitch_r, time_r};
    if (mem_rd_en) rd_data_r <= vmem_r[rd_addr_r];
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_voice_out = out_voice_r;
  assign out_need_fade = out_fade_r;

  // A held key always belongs to a busy voice
  a_key_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (key_r & ~busy_r) == '0)
    else $error("key held on a free voice");

  // Only a steal reports a cut voice
  a_fade_only_steal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fade_r |-> out_status_r == STAT_STOLEN)
    else $error("fade flagged on a non-steal result");

  // A started voice is busy and held right after commit
  a_start_sets_voice: assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire && (act_r == ACT_START) |=>
      busy_r[$past(act_voice_r)] && key_r[$past(act_voice_r)])
    else $error("started voice not marked busy");

  // Kill all leaves every voice free
  a_kill_clears: assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire && (act_r == ACT_KILL) |=> busy_r == '0)
    else $error("voices still busy after kill all");

  // An accepted request moves on to decode
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_DECODE)
    else $error("accepted request not decoded");

endmodule

`default_nettype wire
